// ===== sv/rtcl_pkg.sv =====
package rtcl_pkg;

    localparam int REG_COUNT        = 8;
    localparam int WINDOW_BYTES_DEF = 2048;
    localparam int ADDR_W           = 11;
    localparam int SECS_W           = 38;
    localparam int DIVR_W           = 18;
    localparam int DIVD_W           = 32;

    localparam logic [SECS_W-1:0] TIME_MAX = 38'd253402300799;

    localparam logic [DIVR_W-1:0] DAYS_ERA   = 18'd146097;
    localparam logic [DIVR_W-1:0] DAYS_4Y    = 18'd1460;
    localparam logic [DIVR_W-1:0] DAYS_100Y  = 18'd36524;
    localparam logic [17:0]       DOE_LAST   = 18'd146096;
    localparam logic [DIVD_W-1:0] EPOCH_SHIFT = 32'd719468;

    localparam logic [DIVR_W-1:0] DIV_60  = 18'd60;
    localparam logic [DIVR_W-1:0] DIV_24  = 18'd24;
    localparam logic [DIVR_W-1:0] DIV_7   = 18'd7;
    localparam logic [DIVR_W-1:0] DIV_365 = 18'd365;
    localparam logic [DIVR_W-1:0] DIV_100 = 18'd100;
    localparam logic [DIVR_W-1:0] DIV_153 = 18'd153;
    localparam logic [DIVR_W-1:0] DIV_5   = 18'd5;

    // floor(2^32 / d), the quotient estimate is at most one low
    localparam logic [63:0]       RECIP_ONE = 64'h1_0000_0000;
    localparam logic [DIVD_W-1:0] RCP_60    = 32'(RECIP_ONE / 64'(DIV_60));
    localparam logic [DIVD_W-1:0] RCP_24    = 32'(RECIP_ONE / 64'(DIV_24));
    localparam logic [DIVD_W-1:0] RCP_7     = 32'(RECIP_ONE / 64'(DIV_7));
    localparam logic [DIVD_W-1:0] RCP_365   = 32'(RECIP_ONE / 64'(DIV_365));
    localparam logic [DIVD_W-1:0] RCP_100   = 32'(RECIP_ONE / 64'(DIV_100));
    localparam logic [DIVD_W-1:0] RCP_153   = 32'(RECIP_ONE / 64'(DIV_153));
    localparam logic [DIVD_W-1:0] RCP_5     = 32'(RECIP_ONE / 64'(DIV_5));
    localparam logic [DIVD_W-1:0] RCP_ERA   = 32'(RECIP_ONE / 64'(DAYS_ERA));
    localparam logic [DIVD_W-1:0] RCP_4Y    = 32'(RECIP_ONE / 64'(DAYS_4Y));
    localparam logic [DIVD_W-1:0] RCP_100Y  = 32'(RECIP_ONE / 64'(DAYS_100Y));

    localparam logic [2:0] REG_CTL  = 3'd0;
    localparam logic [2:0] REG_WDAY = 3'd4;
    localparam logic [7:0] BATT_OK  = 8'h80;

    typedef enum logic [1:0] {
        CMD_ZERO,
        CMD_READ,
        CMD_CTL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [2:0]        idx;
        logic [1:0]        lock;
        logic [SECS_W-1:0] secs;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic pop;
    } q_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEC_HI,
        ST_SEC,
        ST_MIN,
        ST_HOUR,
        ST_WDAY,
        ST_ERA,
        ST_D1460,
        ST_D36524,
        ST_YOE,
        ST_Y100,
        ST_MP,
        ST_MDAY,
        ST_CENT
    } state_t;

    // binary value below 100 to two BCD digits
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [3:0] tens;
        logic [6:0] ones;
        tens = 4'd0;
        for (int i = 1; i < 10; i++) begin
            if (v >= 7'(10 * i)) begin
                tens = 4'(i);
            end
        end
        ones = v - 7'(tens) * 7'd10;
        return {tens, ones[3:0]};
    endfunction

endpackage

// ===== sv/rtcl_in_if.sv =====
interface rtcl_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [10:0] address;
    logic [7:0]  write_data;
    logic [37:0] unix_seconds;

    modport source (output valid, operation, address, write_data, unix_seconds, input ready);
    modport sink (input valid, operation, address, write_data, unix_seconds, output ready);
endinterface

// ===== sv/rtcl_out_if.sv =====
interface rtcl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink (input valid, read_data, output ready);
endinterface

// ===== sv/bcd_rtc_register_latch.sv =====
// Real-time clock register block on a byte bus.
// Channel req carries one access per transfer: operation (0 read, 1 write),
// address in the window, write_data and the current unix_seconds.
// Channel rsp returns exactly one read_data byte per access, in order:
// the register byte for reads of the top eight bytes, zero otherwise.
// A write of the control byte stores the lock bits; a rising read-lock bit
// latches the time into BCD registers.
// A read or plain write passes the front queue, then the output register,
// on its way to rsp. A latching write returns its byte without waiting,
// but the back end then runs thirteen constant divisions through one
// shared reciprocal-multiply divider and takes the next access only after
// the last of them. Other accesses sustain one per cycle while rsp does
// not stall. The front queue holds two accesses, so req keeps taking
// transfers while the back end latches or rsp stalls.
// A stalled rsp holds its byte; the back end stops popping the queue,
// and req drops ready once the queue is full.
// Reset clears the lock bits, all time bytes and the queue pointers and count.
module bcd_rtc_register_latch #(
    parameter int WINDOW_BYTES = rtcl_pkg::WINDOW_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rtcl_in_if.sink     req,
    rtcl_out_if.source  rsp
);
    logic             q_valid;
    rtcl_pkg::cmd_t   q_cmd;
    rtcl_pkg::q_ctl_t q_ctl;
    logic             busy;

    // accept and classify, queue up to two accesses
    rtcl_front #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .pop     (q_ctl.pop),
        .q_valid (q_valid),
        .q_cmd   (q_cmd)
    );

    // execute accesses, latch time, drive the response
    rtcl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_ctl   (q_ctl),
        .busy    (busy),
        .rsp     (rsp)
    );

    // pop only from a non-empty queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_ctl.pop |-> q_ctl.valid)
        else $error("queue popped while empty");

    // no access is executed while a latch is in progress
    a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !q_ctl.pop)
        else $error("pop during latch");

    // a new response only follows a pop
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(q_ctl.pop))
        else $error("response without access");

    // a latch starts only from a popped access
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(q_ctl.pop))
        else $error("latch without access");
endmodule

// ===== sv/rtcl_front.sv =====
module rtcl_front #(
    parameter int WINDOW_BYTES = rtcl_pkg::WINDOW_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    rtcl_in_if.sink          req,
    input  logic             pop,
    output logic             q_valid,
    output rtcl_pkg::cmd_t   q_cmd
);
    localparam int BASE = WINDOW_BYTES - rtcl_pkg::REG_COUNT;

    rtcl_pkg::cmd_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       mapped;
    logic [16:0] addr_ext;
    logic [16:0] offs;
    rtcl_pkg::cmd_t cmd;

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_cmd     = mem[rd_ptr_reg];

    // classify the access
    always_comb
    begin
        addr_ext = {6'd0, req.address};
        mapped   = (addr_ext >= 17'(BASE)) && (addr_ext < 17'(WINDOW_BYTES));
        offs     = addr_ext - 17'(BASE);
        cmd.idx  = mapped ? offs[2:0] : 3'd0;
        cmd.lock = req.write_data[7:6];
        cmd.secs = (req.unix_seconds > rtcl_pkg::TIME_MAX) ? rtcl_pkg::TIME_MAX
                                                          : req.unix_seconds;
        if (!mapped) begin
            cmd.kind = rtcl_pkg::CMD_ZERO;
        end else if (!req.operation) begin
            cmd.kind = rtcl_pkg::CMD_READ;
        end else if (cmd.idx == rtcl_pkg::REG_CTL) begin
            cmd.kind = rtcl_pkg::CMD_CTL;
        end else begin
            cmd.kind = rtcl_pkg::CMD_ZERO;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= cmd;
        end
    end
endmodule

// ===== sv/rtcl_div.sv =====
module rtcl_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rtcl_pkg::DIVD_W-1:0] dividend,
    input  logic [rtcl_pkg::DIVR_W-1:0] divisor,
    input  logic [rtcl_pkg::DIVD_W-1:0] magic,
    output logic                        done,
    output logic [rtcl_pkg::DIVD_W-1:0] quo,
    output logic [rtcl_pkg::DIVR_W-1:0] rem
);
    localparam int XW = rtcl_pkg::DIVD_W;
    localparam int DW = rtcl_pkg::DIVR_W;

    logic [XW-1:0]   x_reg, x_next;
    logic [DW-1:0]   d_reg, d_next;
    logic [XW-1:0]   m_reg, m_next;
    logic [2*XW-1:0] p_reg, p_next;
    logic [XW-1:0]   q_reg, q_next;
    logic [XW-1:0]   r_reg, r_next;
    logic [XW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [2:0]      stage_reg, stage_next;
    logic            done_reg, done_next;
    logic [XW-1:0]   qd;

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

    // reciprocal multiply, back-multiply, then one fix-up step
    always_comb
    begin
        x_next     = x_reg;
        d_next     = d_reg;
        m_next     = m_reg;
        stage_next = {stage_reg[1:0], start};
        done_next  = stage_reg[2];
        if (start) begin
            x_next = dividend;
            d_next = divisor;
            m_next = magic;
        end
        p_next = {{XW{1'b0}}, x_reg} * {{XW{1'b0}}, m_reg};
        q_next = p_reg[2*XW-1:XW];
        qd     = q_next * XW'(d_reg);
        r_next = x_reg - qd;
        if (r_reg >= XW'(d_reg)) begin
            quo_next = q_reg + XW'(1);
            rem_next = DW'(r_reg - XW'(d_reg));
        end else begin
            quo_next = q_reg;
            rem_next = DW'(r_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_reg <= 3'd0;
            done_reg  <= 1'b0;
        end else begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        d_reg   <= d_next;
        m_reg   <= m_next;
        p_reg   <= p_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end
endmodule

// ===== sv/rtcl_back.sv =====
module rtcl_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  rtcl_pkg::cmd_t q_cmd,
    output rtcl_pkg::q_ctl_t q_ctl,
    output logic           busy,
    rtcl_out_if.source     rsp
);
    localparam int SW = rtcl_pkg::SECS_W;
    localparam int DW = rtcl_pkg::DIVR_W;
    localparam int XW = rtcl_pkg::DIVD_W;
    // seconds split point: high part first, then remainder with low part
    localparam int SPLIT = 19;

    rtcl_pkg::state_t state_reg, state_next;

    logic [1:0]    lock_reg, lock_next;
    logic [7:0]    tb_reg [rtcl_pkg::REG_COUNT];
    logic [7:0]    tb_next [rtcl_pkg::REG_COUNT];
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_data_reg, out_data_next;
    logic          go_reg, go_next;

    logic [SW-1:0] sat_reg, sat_next;
    logic [XW-1:0] t_reg, t_next;
    logic [5:0]    sec_reg, sec_next;
    logic [5:0]    min_reg, min_next;
    logic [4:0]    hour_reg, hour_next;
    logic [2:0]    wday_reg, wday_next;
    logic [4:0]    era_reg, era_next;
    logic [17:0]   doe_reg, doe_next;
    logic [6:0]    a_reg, a_next;
    logic [2:0]    b_reg, b_next;
    logic [8:0]    yoe_reg, yoe_next;
    logic [17:0]   doy_reg, doy_next;
    logic [3:0]    mp_reg, mp_next;
    logic [4:0]    mday_reg, mday_next;
    logic [3:0]    mon_reg, mon_next;
    logic [13:0]   year_reg, year_next;

    logic          free;
    logic          pop;
    logic          latch;
    logic          div_done;
    logic [XW-1:0] div_quo;
    logic [DW-1:0] div_rem;
    logic [XW-1:0] opa;
    logic [DW-1:0] opb;
    logic [XW-1:0] opm;
    logic [17:0]   yoe_days;
    logic [3:0]    mon_calc;

    assign free  = !out_valid_reg || rsp.ready;
    assign pop   = q_valid && (state_reg == rtcl_pkg::ST_IDLE) && free;
    assign latch = (q_cmd.kind == rtcl_pkg::CMD_CTL) && !lock_reg[0] && q_cmd.lock[0];
    assign q_ctl.valid = q_valid;
    assign q_ctl.pop   = pop;
    assign busy        = (state_reg != rtcl_pkg::ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;

    rtcl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (go_reg),
        .dividend (opa),
        .divisor  (opb),
        .magic    (opm),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rtcl_pkg::ST_IDLE:   if (pop && latch) state_next = rtcl_pkg::ST_SEC_HI;
            rtcl_pkg::ST_SEC_HI: if (div_done) state_next = rtcl_pkg::ST_SEC;
            rtcl_pkg::ST_SEC:    if (div_done) state_next = rtcl_pkg::ST_MIN;
            rtcl_pkg::ST_MIN:    if (div_done) state_next = rtcl_pkg::ST_HOUR;
            rtcl_pkg::ST_HOUR:   if (div_done) state_next = rtcl_pkg::ST_WDAY;
            rtcl_pkg::ST_WDAY:   if (div_done) state_next = rtcl_pkg::ST_ERA;
            rtcl_pkg::ST_ERA:    if (div_done) state_next = rtcl_pkg::ST_D1460;
            rtcl_pkg::ST_D1460:  if (div_done) state_next = rtcl_pkg::ST_D36524;
            rtcl_pkg::ST_D36524: if (div_done) state_next = rtcl_pkg::ST_YOE;
            rtcl_pkg::ST_YOE:    if (div_done) state_next = rtcl_pkg::ST_Y100;
            rtcl_pkg::ST_Y100:   if (div_done) state_next = rtcl_pkg::ST_MP;
            rtcl_pkg::ST_MP:     if (div_done) state_next = rtcl_pkg::ST_MDAY;
            rtcl_pkg::ST_MDAY:   if (div_done) state_next = rtcl_pkg::ST_CENT;
            rtcl_pkg::ST_CENT:   if (div_done) state_next = rtcl_pkg::ST_IDLE;
            default:             state_next = rtcl_pkg::ST_IDLE;
        endcase
    end

    // divider operands per step
    always_comb
    begin
        yoe_days = 18'(yoe_reg) * 18'd365 + 18'(yoe_reg[8:2]);
        unique case (state_reg)
            rtcl_pkg::ST_SEC_HI:
            begin
                opa = XW'(sat_reg[SW-1:SPLIT]);
                opb = rtcl_pkg::DIV_60;
                opm = rtcl_pkg::RCP_60;
            end
            rtcl_pkg::ST_SEC:
            begin
                opa = XW'({sec_reg, sat_reg[SPLIT-1:0]});
                opb = rtcl_pkg::DIV_60;
                opm = rtcl_pkg::RCP_60;
            end
            rtcl_pkg::ST_MIN:
            begin
                opa = t_reg;
                opb = rtcl_pkg::DIV_60;
                opm = rtcl_pkg::RCP_60;
            end
            rtcl_pkg::ST_HOUR:
            begin
                opa = t_reg;
                opb = rtcl_pkg::DIV_24;
                opm = rtcl_pkg::RCP_24;
            end
            rtcl_pkg::ST_WDAY:
            begin
                opa = t_reg + XW'(4);
                opb = rtcl_pkg::DIV_7;
                opm = rtcl_pkg::RCP_7;
            end
            rtcl_pkg::ST_ERA:
            begin
                opa = t_reg + rtcl_pkg::EPOCH_SHIFT;
                opb = rtcl_pkg::DAYS_ERA;
                opm = rtcl_pkg::RCP_ERA;
            end
            rtcl_pkg::ST_D1460:
            begin
                opa = XW'(doe_reg);
                opb = rtcl_pkg::DAYS_4Y;
                opm = rtcl_pkg::RCP_4Y;
            end
            rtcl_pkg::ST_D36524:
            begin
                opa = XW'(doe_reg);
                opb = rtcl_pkg::DAYS_100Y;
                opm = rtcl_pkg::RCP_100Y;
            end
            rtcl_pkg::ST_YOE:
            begin
                opa = XW'(doe_reg - 18'(a_reg) + 18'(b_reg)
                          - 18'(doe_reg == rtcl_pkg::DOE_LAST));
                opb = rtcl_pkg::DIV_365;
                opm = rtcl_pkg::RCP_365;
            end
            rtcl_pkg::ST_Y100:
            begin
                opa = XW'(yoe_reg);
                opb = rtcl_pkg::DIV_100;
                opm = rtcl_pkg::RCP_100;
            end
            rtcl_pkg::ST_MP:
            begin
                opa = XW'(21'(doy_reg) * 21'd5 + 21'd2);
                opb = rtcl_pkg::DIV_153;
                opm = rtcl_pkg::RCP_153;
            end
            rtcl_pkg::ST_MDAY:
            begin
                opa = XW'(12'(mp_reg) * 12'd153 + 12'd2);
                opb = rtcl_pkg::DIV_5;
                opm = rtcl_pkg::RCP_5;
            end
            rtcl_pkg::ST_CENT:
            begin
                opa = XW'(year_reg);
                opb = rtcl_pkg::DIV_100;
                opm = rtcl_pkg::RCP_100;
            end
            default:
            begin
                opa = '0;
                opb = rtcl_pkg::DIV_60;
                opm = rtcl_pkg::RCP_60;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        lock_next      = lock_reg;
        tb_next        = tb_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        go_next        = (state_next != state_reg) && (state_next != rtcl_pkg::ST_IDLE);
        sat_next  = sat_reg;
        t_next    = t_reg;
        sec_next  = sec_reg;
        min_next  = min_reg;
        hour_next = hour_reg;
        wday_next = wday_reg;
        era_next  = era_reg;
        doe_next  = doe_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        yoe_next  = yoe_reg;
        doy_next  = doy_reg;
        mp_next   = mp_reg;
        mday_next = mday_reg;
        mon_next  = mon_reg;
        year_next = year_reg;
        mon_calc  = (mp_reg < 4'd10) ? mp_reg + 4'd3 : mp_reg - 4'd9;

        if (pop) begin
            out_valid_next = 1'b1;
            out_data_next  = 8'd0;
            unique case (q_cmd.kind)
                rtcl_pkg::CMD_READ:
                begin
                    out_data_next = tb_reg[q_cmd.idx];
                    if (q_cmd.idx == rtcl_pkg::REG_CTL) begin
                        out_data_next = tb_reg[q_cmd.idx] | {lock_reg, 6'd0};
                    end else if (q_cmd.idx == rtcl_pkg::REG_WDAY) begin
                        out_data_next = tb_reg[q_cmd.idx] | rtcl_pkg::BATT_OK;
                    end
                end
                rtcl_pkg::CMD_CTL:
                begin
                    lock_next = q_cmd.lock;
                    sat_next  = q_cmd.secs;
                end
                default: out_data_next = 8'd0;
            endcase
        end

        if (div_done) begin
            unique case (state_reg)
                rtcl_pkg::ST_SEC_HI:
                begin
                    // hold the high quotient and carry the remainder down
                    t_next   = {div_quo[12:0], {SPLIT{1'b0}}};
                    sec_next = div_rem[5:0];
                end
                rtcl_pkg::ST_SEC:
                begin
                    sec_next = div_rem[5:0];
                    t_next   = t_reg | XW'(div_quo[SPLIT-1:0]);
                end
                rtcl_pkg::ST_MIN:    begin min_next  = div_rem[5:0]; t_next = div_quo; end
                rtcl_pkg::ST_HOUR:   begin hour_next = div_rem[4:0]; t_next = div_quo; end
                rtcl_pkg::ST_WDAY:   wday_next = div_rem[2:0] + 3'd1;
                rtcl_pkg::ST_ERA:    begin era_next = div_quo[4:0]; doe_next = div_rem; end
                rtcl_pkg::ST_D1460:  a_next = div_quo[6:0];
                rtcl_pkg::ST_D36524: b_next = div_quo[2:0];
                rtcl_pkg::ST_YOE:    yoe_next = div_quo[8:0];
                rtcl_pkg::ST_Y100:   doy_next = doe_reg - (yoe_days - 18'(div_quo[1:0]));
                rtcl_pkg::ST_MP:     mp_next = div_quo[3:0];
                rtcl_pkg::ST_MDAY:
                begin
                    mday_next = 5'(doy_reg - div_quo[17:0] + 18'd1);
                    mon_next  = mon_calc;
                    year_next = 14'(yoe_reg) + 14'(era_reg) * 14'd400
                              + 14'(mon_calc <= 4'd2);
                end
                rtcl_pkg::ST_CENT:
                begin
                    tb_next[0] = rtcl_pkg::to_bcd(div_quo[6:0]);
                    tb_next[1] = rtcl_pkg::to_bcd(7'(sec_reg));
                    tb_next[2] = rtcl_pkg::to_bcd(7'(min_reg));
                    tb_next[3] = rtcl_pkg::to_bcd(7'(hour_reg));
                    tb_next[4] = rtcl_pkg::to_bcd(7'(wday_reg));
                    tb_next[5] = rtcl_pkg::to_bcd(7'(mday_reg));
                    tb_next[6] = rtcl_pkg::to_bcd(7'(mon_reg));
                    tb_next[7] = rtcl_pkg::to_bcd(div_rem[6:0]);
                end
                default: t_next = t_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= rtcl_pkg::ST_IDLE;
            lock_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
            go_reg        <= 1'b0;
            for (int i = 0; i < rtcl_pkg::REG_COUNT; i++) begin
                tb_reg[i] <= 8'd0;
            end
        end else begin
            state_reg     <= state_next;
            lock_reg      <= lock_next;
            out_valid_reg <= out_valid_next;
            go_reg        <= go_next;
            tb_reg        <= tb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        sat_reg  <= sat_next;
        t_reg    <= t_next;
        sec_reg  <= sec_next;
        min_reg  <= min_next;
        hour_reg <= hour_next;
        wday_reg <= wday_next;
        era_reg  <= era_next;
        doe_reg  <= doe_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        yoe_reg  <= yoe_next;
        doy_reg  <= doy_next;
        mp_reg   <= mp_next;
        mday_reg <= mday_next;
        mon_reg  <= mon_next;
        year_reg <= year_next;
    end
endmodule
